/* rtl/qvr_pkg.sv */
// shared widths, types and the rounding helper for the quaternion vector rotator
`default_nettype none

package qvr_pkg;

    localparam int QUAT_BITS  = 16;
    localparam int VEC_BITS   = 16;
    localparam int OUT_BITS   = 18;
    localparam int QUAT_FRAC  = QUAT_BITS - 2;
    localparam int PROD_SHIFT = 2 * QUAT_FRAC;

    // product of two quaternion parts, matrix entry, entry times component, row sum
    localparam int PROD_W = 2 * QUAT_BITS;
    localparam int MAT_W  = PROD_W + 2;
    localparam int TERM_W = MAT_W + VEC_BITS;
    localparam int SUM_W  = TERM_W + 2;

    typedef logic signed [QUAT_BITS-1:0] quat_t;
    typedef logic signed [VEC_BITS-1:0]  vec_t;
    typedef logic signed [PROD_W-1:0]    prod_t;
    typedef logic signed [MAT_W-1:0]     mat_t;
    typedef logic signed [TERM_W-1:0]    term_t;
    typedef logic signed [SUM_W-1:0]     sum_t;
    typedef logic signed [OUT_BITS-1:0]  out_t;

    typedef struct packed {
        logic clip;
        out_t value;
    } sat_t;

    localparam out_t OUT_MAX  = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam out_t OUT_MIN  = {1'b1, {(OUT_BITS-1){1'b0}}};
    localparam sum_t SAT_HI   = sum_t'(OUT_MAX);
    localparam sum_t SAT_LO   = sum_t'(OUT_MIN);
    localparam sum_t RND_HALF = sum_t'(1) <<< (PROD_SHIFT - 1);

    // add half, floor by the product scale, then clamp to the output range
    function automatic sat_t round_sat(sum_t s);
        sum_t t;
        sat_t r;
        t = (s + RND_HALF) >>> PROD_SHIFT;
        if (t > SAT_HI) begin
            r.clip  = 1'b1;
            r.value = OUT_MAX;
        end else if (t < SAT_LO) begin
            r.clip  = 1'b1;
            r.value = OUT_MIN;
        end else begin
            r.clip  = 1'b0;
            r.value = t[OUT_BITS-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/quaternion_vector_rotate.sv */
// quaternion vector rotator: five-stage pipeline from quaternion and vector to rotated vector
//
// usage:
//   s_ channel carries one request: quaternion rot_w/x/y/z (signed Q2.14) and
//   vector vec_x/y/z (signed integers). m_ channel returns the rotated vector
//   out_x/y/z, rounded to nearest and saturated to 18 bits, plus a clipped flag.
//   order: a request accepted on s_ passes through part products, matrix
//   entries, entry times component, row sums, then round and saturate, and
//   the result shows on m_valid.
//   throughput: one request per cycle; each of the five register stages has
//   its own valid bit and takes a new request whenever the one after it moves.
//   stall: while m_ready is low the result holds on m_ and stages behind it
//   keep filling; s_ready drops only once every stage holds a request.
//   reset: aresetn low clears all valid bits; the pipeline comes up empty.
`default_nettype none

module quaternion_vector_rotate (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         s_valid,
    output logic                        s_ready,
    input  wire  qvr_pkg::quat_t        s_rot_w,
    input  wire  qvr_pkg::quat_t        s_rot_x,
    input  wire  qvr_pkg::quat_t        s_rot_y,
    input  wire  qvr_pkg::quat_t        s_rot_z,
    input  wire  qvr_pkg::vec_t         s_vec_x,
    input  wire  qvr_pkg::vec_t         s_vec_y,
    input  wire  qvr_pkg::vec_t         s_vec_z,
    output logic                        m_valid,
    input  wire                         m_ready,
    output qvr_pkg::out_t               m_out_x,
    output qvr_pkg::out_t               m_out_y,
    output qvr_pkg::out_t               m_out_z,
    output logic                        m_clipped
);

    // stage valid bits
    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg, out_vld_reg;
    logic en1, en2, en3, en4, en_out;

    // stage 1: products of quaternion parts
    qvr_pkg::prod_t aa_reg, bb_reg, cc_reg, dd_reg;
    qvr_pkg::prod_t bc_reg, bd_reg, ac_reg, ad_reg, ab_reg, cd_reg;
    qvr_pkg::vec_t  v1_reg [3];

    // stage 2: matrix entries, row major
    qvr_pkg::mat_t  mat_reg  [9];
    qvr_pkg::mat_t  mat_next [9];
    qvr_pkg::vec_t  v2_reg   [3];

    // stage 3: entry times component
    qvr_pkg::term_t term_reg [9];

    // stage 4: row sums
    qvr_pkg::sum_t  sum_reg  [3];

    // output register
    qvr_pkg::sat_t  sat_next [3];
    qvr_pkg::out_t  out_x_reg, out_y_reg, out_z_reg;
    logic           clip_reg;

    // a stage moves when it is empty or the one after it moves
    assign en_out  = !out_vld_reg || m_ready;
    assign en4     = !vld4_reg || en_out;
    assign en3     = !vld3_reg || en4;
    assign en2     = !vld2_reg || en3;
    assign en1     = !vld1_reg || en2;
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg    <= 1'b0;
            vld2_reg    <= 1'b0;
            vld3_reg    <= 1'b0;
            vld4_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (en1)    vld1_reg    <= s_valid;
            if (en2)    vld2_reg    <= vld1_reg;
            if (en3)    vld3_reg    <= vld2_reg;
            if (en4)    vld4_reg    <= vld3_reg;
            if (en_out) out_vld_reg <= vld4_reg;
        end
    end

    always_comb begin
        // doubled cross products fit after the pair is summed
        mat_next[0] = qvr_pkg::mat_t'(aa_reg) + qvr_pkg::mat_t'(bb_reg)
                    - qvr_pkg::mat_t'(cc_reg) - qvr_pkg::mat_t'(dd_reg);
        mat_next[1] = (qvr_pkg::mat_t'(bc_reg) + qvr_pkg::mat_t'(ad_reg)) <<< 1;
        mat_next[2] = (qvr_pkg::mat_t'(bd_reg) - qvr_pkg::mat_t'(ac_reg)) <<< 1;
        mat_next[3] = (qvr_pkg::mat_t'(bc_reg) - qvr_pkg::mat_t'(ad_reg)) <<< 1;
        mat_next[4] = qvr_pkg::mat_t'(aa_reg) + qvr_pkg::mat_t'(cc_reg)
                    - qvr_pkg::mat_t'(bb_reg) - qvr_pkg::mat_t'(dd_reg);
        mat_next[5] = (qvr_pkg::mat_t'(ab_reg) + qvr_pkg::mat_t'(cd_reg)) <<< 1;
        mat_next[6] = (qvr_pkg::mat_t'(ac_reg) + qvr_pkg::mat_t'(bd_reg)) <<< 1;
        mat_next[7] = (qvr_pkg::mat_t'(cd_reg) - qvr_pkg::mat_t'(ab_reg)) <<< 1;
        mat_next[8] = qvr_pkg::mat_t'(aa_reg) + qvr_pkg::mat_t'(dd_reg)
                    - qvr_pkg::mat_t'(bb_reg) - qvr_pkg::mat_t'(cc_reg);
    end

    always_comb begin
        sat_next[0] = qvr_pkg::round_sat(sum_reg[0]);
        sat_next[1] = qvr_pkg::round_sat(sum_reg[1]);
        sat_next[2] = qvr_pkg::round_sat(sum_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            aa_reg    <= qvr_pkg::prod_t'(s_rot_w) * qvr_pkg::prod_t'(s_rot_w);
            bb_reg    <= qvr_pkg::prod_t'(s_rot_x) * qvr_pkg::prod_t'(s_rot_x);
            cc_reg    <= qvr_pkg::prod_t'(s_rot_y) * qvr_pkg::prod_t'(s_rot_y);
            dd_reg    <= qvr_pkg::prod_t'(s_rot_z) * qvr_pkg::prod_t'(s_rot_z);
            bc_reg    <= qvr_pkg::prod_t'(s_rot_x) * qvr_pkg::prod_t'(s_rot_y);
            bd_reg    <= qvr_pkg::prod_t'(s_rot_x) * qvr_pkg::prod_t'(s_rot_z);
            ac_reg    <= qvr_pkg::prod_t'(s_rot_w) * qvr_pkg::prod_t'(s_rot_y);
            ad_reg    <= qvr_pkg::prod_t'(s_rot_w) * qvr_pkg::prod_t'(s_rot_z);
            ab_reg    <= qvr_pkg::prod_t'(s_rot_w) * qvr_pkg::prod_t'(s_rot_x);
            cd_reg    <= qvr_pkg::prod_t'(s_rot_y) * qvr_pkg::prod_t'(s_rot_z);
            v1_reg[0] <= s_vec_x;
            v1_reg[1] <= s_vec_y;
            v1_reg[2] <= s_vec_z;
        end
        if (en2) begin
            mat_reg <= mat_next;
            v2_reg  <= v1_reg;
        end
        if (en3) begin
            term_reg[0] <= qvr_pkg::term_t'(mat_reg[0]) * qvr_pkg::term_t'(v2_reg[0]);
            term_reg[1] <= qvr_pkg::term_t'(mat_reg[1]) * qvr_pkg::term_t'(v2_reg[1]);
            term_reg[2] <= qvr_pkg::term_t'(mat_reg[2]) * qvr_pkg::term_t'(v2_reg[2]);
            term_reg[3] <= qvr_pkg::term_t'(mat_reg[3]) * qvr_pkg::term_t'(v2_reg[0]);
            term_reg[4] <= qvr_pkg::term_t'(mat_reg[4]) * qvr_pkg::term_t'(v2_reg[1]);
            term_reg[5] <= qvr_pkg::term_t'(mat_reg[5]) * qvr_pkg::term_t'(v2_reg[2]);
            term_reg[6] <= qvr_pkg::term_t'(mat_reg[6]) * qvr_pkg::term_t'(v2_reg[0]);
            term_reg[7] <= qvr_pkg::term_t'(mat_reg[7]) * qvr_pkg::term_t'(v2_reg[1]);
            term_reg[8] <= qvr_pkg::term_t'(mat_reg[8]) * qvr_pkg::term_t'(v2_reg[2]);
        end
        if (en4) begin
            sum_reg[0] <= qvr_pkg::sum_t'(term_reg[0]) + qvr_pkg::sum_t'(term_reg[1])
                        + qvr_pkg::sum_t'(term_reg[2]);
            sum_reg[1] <= qvr_pkg::sum_t'(term_reg[3]) + qvr_pkg::sum_t'(term_reg[4])
                        + qvr_pkg::sum_t'(term_reg[5]);
            sum_reg[2] <= qvr_pkg::sum_t'(term_reg[6]) + qvr_pkg::sum_t'(term_reg[7])
                        + qvr_pkg::sum_t'(term_reg[8]);
        end
        if (en_out) begin
            out_x_reg <= sat_next[0].value;
            out_y_reg <= sat_next[1].value;
            out_z_reg <= sat_next[2].value;
            clip_reg  <= sat_next[0].clip | sat_next[1].clip | sat_next[2].clip;
        end
    end

    assign m_valid   = out_vld_reg;
    assign m_out_x   = out_x_reg;
    assign m_out_y   = out_y_reg;
    assign m_out_z   = out_z_reg;
    assign m_clipped = clip_reg;

endmodule

`default_nettype wire

/* rtl/qvr_checker.sv */
// port-level checks for the quaternion vector rotator, bound to the top level
`default_nettype none

module qvr_checker (
    input wire                  aclk,
    input wire                  aresetn,
    input wire                  s_valid,
    input wire                  s_ready,
    input wire                  m_valid,
    input wire                  m_ready,
    input wire qvr_pkg::out_t   m_out_x,
    input wire qvr_pkg::out_t   m_out_y,
    input wire qvr_pkg::out_t   m_out_z,
    input wire                  m_clipped
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_x) && $stable(m_out_y)
            && $stable(m_out_z) && $stable(m_clipped))
        else $error("stalled result changed");

    // reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a receiver that takes results never holds back a request
    a_flow: assert property (@(posedge aclk)
        m_ready |-> s_ready)
        else $error("request blocked while receiver ready");

    // a clipped result sits on a rail in at least one component
    a_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_clipped |->
            m_out_x == qvr_pkg::OUT_MAX || m_out_x == qvr_pkg::OUT_MIN ||
            m_out_y == qvr_pkg::OUT_MAX || m_out_y == qvr_pkg::OUT_MIN ||
            m_out_z == qvr_pkg::OUT_MAX || m_out_z == qvr_pkg::OUT_MIN)
        else $error("clipped set with no saturated component");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_out_x   (m_out_x),
    .m_out_y   (m_out_y),
    .m_out_z   (m_out_z),
    .m_clipped (m_clipped)
);

`default_nettype wire

/* sim/quaternion_vector_rotate_checker.sv */
// checker for the quaternion vector rotator: predicts each rotated vector and compares results
module quaternion_vector_rotate_checker (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    input  wire logic            s_ready,
    input  wire qvr_pkg::quat_t  s_rot_w,
    input  wire qvr_pkg::quat_t  s_rot_x,
    input  wire qvr_pkg::quat_t  s_rot_y,
    input  wire qvr_pkg::quat_t  s_rot_z,
    input  wire qvr_pkg::vec_t   s_vec_x,
    input  wire qvr_pkg::vec_t   s_vec_y,
    input  wire qvr_pkg::vec_t   s_vec_z,
    input  wire logic            m_valid,
    input  wire logic            m_ready,
    input  wire qvr_pkg::out_t   m_out_x,
    input  wire qvr_pkg::out_t   m_out_y,
    input  wire qvr_pkg::out_t   m_out_z,
    input  wire logic            m_clipped,
    output int                   errors,
    output int                   pending,
    output int                   requests_seen,
    output int                   results_seen,
    output int                   clipped_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic          clip;
        qvr_pkg::out_t x;
        qvr_pkg::out_t y;
        qvr_pkg::out_t z;
    } rotated_t;

    rotated_t rotated_q[$];

    initial begin
        errors        = 0;
        pending       = 0;
        requests_seen = 0;
        results_seen  = 0;
        clipped_seen  = 0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // add half of the product scale, floor, then clamp to the output width
    function automatic qvr_pkg::out_t scale_and_clamp(input longint s, inout logic clip);
        longint t;
        longint hi;
        longint lo;
        t  = (s + (longint'(1) <<< (qvr_pkg::PROD_SHIFT - 1))) >>> qvr_pkg::PROD_SHIFT;
        hi = (longint'(1) <<< (qvr_pkg::OUT_BITS - 1)) - 1;
        lo = -(longint'(1) <<< (qvr_pkg::OUT_BITS - 1));
        if (t > hi) begin
            t    = hi;
            clip = 1'b1;
        end
        if (t < lo) begin
            t    = lo;
            clip = 1'b1;
        end
        return qvr_pkg::out_t'(t);
    endfunction

    function automatic rotated_t rotate_vector(input qvr_pkg::quat_t qa,
                                               input qvr_pkg::quat_t qb,
                                               input qvr_pkg::quat_t qc,
                                               input qvr_pkg::quat_t qd,
                                               input qvr_pkg::vec_t vx,
                                               input qvr_pkg::vec_t vy,
                                               input qvr_pkg::vec_t vz);
        longint a, b, c, d;
        longint aa, bb, cc, dd, bc2, bd2, ac2, ad2, ab2, cd2;
        longint r00, r01, r02, r10, r11, r12, r20, r21, r22;
        longint px, py, pz;
        rotated_t r;
        logic clip;
        a = qa;
        b = qb;
        c = qc;
        d = qd;
        aa  = a * a;
        bb  = b * b;
        cc  = c * c;
        dd  = d * d;
        bc2 = 2 * b * c;
        bd2 = 2 * b * d;
        ac2 = 2 * a * c;
        ad2 = 2 * a * d;
        ab2 = 2 * a * b;
        cd2 = 2 * c * d;
        r00 = aa + bb - cc - dd;
        r01 = bc2 + ad2;
        r02 = bd2 - ac2;
        r10 = bc2 - ad2;
        r11 = aa + cc - bb - dd;
        r12 = ab2 + cd2;
        r20 = ac2 + bd2;
        r21 = cd2 - ab2;
        r22 = aa + dd - bb - cc;
        px = r00 * longint'(vx) + r01 * longint'(vy) + r02 * longint'(vz);
        py = r10 * longint'(vx) + r11 * longint'(vy) + r12 * longint'(vz);
        pz = r20 * longint'(vx) + r21 * longint'(vy) + r22 * longint'(vz);
        clip   = 1'b0;
        r.x    = scale_and_clamp(px, clip);
        r.y    = scale_and_clamp(py, clip);
        r.z    = scale_and_clamp(pz, clip);
        r.clip = clip;
        return r;
    endfunction

    always @(posedge aclk) begin
        rotated_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                rotated_q.push_back(rotate_vector(s_rot_w, s_rot_x, s_rot_y, s_rot_z,
                                                  s_vec_x, s_vec_y, s_vec_z));
                requests_seen++;
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_clipped) clipped_seen++;
                if (rotated_q.size() == 0) begin
                    $display("%0t: result with no request outstanding", $realtime);
                    errors++;
                end else begin
                    want = rotated_q.pop_front();
                    if (m_out_x !== want.x) report_mismatch("out_x", m_out_x, want.x);
                    if (m_out_y !== want.y) report_mismatch("out_y", m_out_y, want.y);
                    if (m_out_z !== want.z) report_mismatch("out_z", m_out_z, want.z);
                    if (m_clipped !== want.clip)
                        report_mismatch("clipped", m_clipped, want.clip);
                end
            end
            pending = rotated_q.size();
        end
    end

endmodule

/* sim/quaternion_vector_rotate_test.sv */
// top of the quaternion vector rotator testbench: clock, reset, requests and verdict
module quaternion_vector_rotate_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 1530;
    localparam int STEADY_FIRST    = 500;
    localparam int STEADY_LAST     = 800;

    logic           aclk;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    qvr_pkg::quat_t s_rot_w, s_rot_x, s_rot_y, s_rot_z;
    qvr_pkg::vec_t  s_vec_x, s_vec_y, s_vec_z;
    logic           m_valid;
    logic           m_ready;
    qvr_pkg::out_t  m_out_x, m_out_y, m_out_z;
    logic           m_clipped;

    int errors, pending, requests_seen, results_seen, clipped_seen;
    bit steady;

    quaternion_vector_rotate dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rot_w   (s_rot_w),
        .s_rot_x   (s_rot_x),
        .s_rot_y   (s_rot_y),
        .s_rot_z   (s_rot_z),
        .s_vec_x   (s_vec_x),
        .s_vec_y   (s_vec_y),
        .s_vec_z   (s_vec_z),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_x   (m_out_x),
        .m_out_y   (m_out_y),
        .m_out_z   (m_out_z),
        .m_clipped (m_clipped)
    );

    quaternion_vector_rotate_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rot_w       (s_rot_w),
        .s_rot_x       (s_rot_x),
        .s_rot_y       (s_rot_y),
        .s_rot_z       (s_rot_z),
        .s_vec_x       (s_vec_x),
        .s_vec_y       (s_vec_y),
        .s_vec_z       (s_vec_z),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_x       (m_out_x),
        .m_out_y       (m_out_y),
        .m_out_z       (m_out_z),
        .m_clipped     (m_clipped),
        .errors        (errors),
        .pending       (pending),
        .requests_seen (requests_seen),
        .results_seen  (results_seen),
        .clipped_seen  (clipped_seen)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // result side stalls at random, except inside the steady window
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady ? 1'b1 : ($urandom_range(99) >= 17);
        end
    end

    // present one request and hold it until the edge that takes it
    task automatic send_request(input qvr_pkg::quat_t w, input qvr_pkg::quat_t x,
                                input qvr_pkg::quat_t y, input qvr_pkg::quat_t z,
                                input qvr_pkg::vec_t vx, input qvr_pkg::vec_t vy,
                                input qvr_pkg::vec_t vz);
        bit taken;
        // each cycle idles with the same odds, so gaps stay short
        if (!steady) begin
            while ($urandom_range(99) < 17) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_rot_w <= w;
        s_rot_x <= x;
        s_rot_y <= y;
        s_rot_z <= z;
        s_vec_x <= vx;
        s_vec_y <= vy;
        s_vec_z <= vz;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
    endtask

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            3: return 16'h0000;
            4: return 16'h0001;
            5: return 16'h4000;
            6: return 16'hc000;
            default: return 16'($urandom);
        endcase
    endfunction

    // raw noise and bounded-component rotations in equal share, plus single-axis turns and extremes
    task automatic send_random();
        int             mode;
        qvr_pkg::quat_t w, x, y, z;
        qvr_pkg::vec_t  vx, vy, vz;
        mode = $urandom_range(99);
        vx   = qvr_pkg::vec_t'($urandom);
        vy   = qvr_pkg::vec_t'($urandom);
        vz   = qvr_pkg::vec_t'($urandom);
        if (mode < 35) begin
            w = qvr_pkg::quat_t'($urandom);
            x = qvr_pkg::quat_t'($urandom);
            y = qvr_pkg::quat_t'($urandom);
            z = qvr_pkg::quat_t'($urandom);
        end else if (mode < 70) begin
            w = qvr_pkg::quat_t'(int'($urandom_range(23170)) - 11585);
            x = qvr_pkg::quat_t'(int'($urandom_range(23170)) - 11585);
            y = qvr_pkg::quat_t'(int'($urandom_range(23170)) - 11585);
            z = qvr_pkg::quat_t'(int'($urandom_range(23170)) - 11585);
        end else if (mode < 88) begin
            w = qvr_pkg::quat_t'(int'($urandom_range(32768)) - 16384);
            x = 0;
            y = 0;
            z = 0;
            case ($urandom_range(2))
                0: x = qvr_pkg::quat_t'(int'($urandom_range(32768)) - 16384);
                1: y = qvr_pkg::quat_t'(int'($urandom_range(32768)) - 16384);
                default: z = qvr_pkg::quat_t'(int'($urandom_range(32768)) - 16384);
            endcase
        end else begin
            w  = pick_extreme();
            x  = pick_extreme();
            y  = pick_extreme();
            z  = pick_extreme();
            vx = pick_extreme();
            vy = pick_extreme();
            vz = pick_extreme();
        end
        send_request(w, x, y, z, vx, vy, vz);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_rot_w = '0;
        s_rot_x = '0;
        s_rot_y = '0;
        s_rot_z = '0;
        s_vec_x = '0;
        s_vec_y = '0;
        s_vec_z = '0;
        steady  = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // identity rotation across the vector extremes
        send_request(16384, 0, 0, 0, 32767, -32768, 0);
        send_request(16384, 0, 0, 0, -1, 1, -32768);
        // zero quaternion wipes the vector
        send_request(0, 0, 0, 0, 32767, 32767, 32767);
        // quarter turns about each axis
        send_request(11585, 0, 0, 11585, 1000, -2000, 3000);
        send_request(11585, 11585, 0, 0, 1000, -2000, 3000);
        send_request(11585, 0, 11585, 0, 1000, -2000, 3000);
        // half turn about x
        send_request(0, 16384, 0, 0, 12345, -12345, 32767);
        // unnormalized: scaled by the squared norm, just inside range at the edges
        send_request(-32768, 0, 0, 0, 32767, -32768, -1);
        send_request(32767, 0, 0, 0, -32768, 32767, 1);
        // exact halves round toward plus infinity; quarters round to nearest
        send_request(8192, 0, 0, 0, 2, -2, -6);
        send_request(8192, 0, 0, 0, 1, -1, 3);
        send_request(0, 8192, 0, 0, -2, 2, 6);
        // saturation high and low
        send_request(-32768, -32768, -32768, -32768, 32767, 32767, 32767);
        send_request(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
        send_request(32767, 32767, -32768, 32767, -32768, 32767, -32768);
        send_request(32767, -32768, 32767, -32768, 32767, -32768, 32767);
        // every input bit high, small odd values, then every input at its maximum
        send_request(-1, -1, -1, -1, -1, -1, -1);
        send_request(1, -1, 1, -1, 1, -1, 1);
        send_request(32767, 32767, 32767, 32767, 32767, 32767, 32767);

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            steady = (i >= STEADY_FIRST && i < STEADY_LAST);
            send_random();
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        // let the checker count the last request before draining
        do @(posedge aclk); while (pending != 0);
        repeat (20) @(posedge aclk);

        $display("covered %0d requests: directed extremes, quarter and half turns,",
                 requests_seen);
        $display("half-way rounding, saturation, random rotations; %0d results, %0d clipped",
                 results_seen, clipped_seen);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #400us;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
